// ----- hw/rtl/otsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otsm_pkg - shared types and constants for the object track status machine
// Payload words, register file view, controller commands and status coding.
// ----------------------------------------------------------------------------

package otsm_pkg;

	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 8;
	localparam int TICK_BITS  = 8;
	localparam int DISP_BITS  = 24;

	// 0.99 as Q16
	localparam int DECAY_Q16   = 64881;
	localparam int DECAY_SHIFT = 16;

	localparam logic OP_DETECT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [2:0] STATUS_STATIONARY = 3'd0;
	localparam logic [2:0] STATUS_MOVING     = 3'd1;
	localparam logic [2:0] STATUS_OCCLUDED   = 3'd2;
	localparam logic [2:0] STATUS_GONE       = 3'd3;
	localparam logic [2:0] STATUS_NONE       = 3'd4;

	typedef struct packed {
		logic                  operation;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [COLOR_BITS-1:0] color;
		logic                  check_color;
	} det_word_t;

	typedef struct packed {
		logic                        accepted;
		logic [2:0]                  status;
		logic                        in_motion;
		logic signed [DISP_BITS-1:0] disp_x;
		logic signed [DISP_BITS-1:0] disp_y;
	} res_word_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] mean_color;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COLOR_BITS-1:0] color_tolerance;
		logic [COORD_BITS-1:0] motion_threshold;
		logic [TICK_BITS-1:0]  occlude_ticks;
		logic [TICK_BITS-1:0]  gone_ticks;
		logic                  tracking_enabled;
	} cfg_t;

	// position load on a start_x / start_y write
	typedef struct packed {
		logic                  ld_x;
		logic                  ld_y;
		logic [COORD_BITS-1:0] value;
	} obj_load_t;

	typedef enum logic [2:0] {
		MUL_DECAY_X,
		MUL_DECAY_Y,
		MUL_SQUARE_X,
		MUL_SQUARE_Y,
		MUL_THRESH
	} mul_sel_t;

	typedef struct packed {
		logic     ld_item;
		mul_sel_t mul_sel;
		logic     ld_dx;
		logic     ld_dy;
		logic     sum_ld;
		logic     sum_add;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic is_update;
	} stat_t;

	function automatic logic [2:0] status_code(input logic vis, input logic mov,
			input logic occ, input logic gone);
		logic [2:0] code;
		if (vis && !mov && !gone && !occ)
			code = STATUS_STATIONARY;
		else if (vis && mov && !gone && !occ)
			code = STATUS_MOVING;
		else if (occ && !gone)
			code = STATUS_OCCLUDED;
		else if (gone)
			code = STATUS_GONE;
		else
			code = STATUS_NONE;
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/otsm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otsm_ctrl - sequencer for the object track status machine
// Steps the shared multiplier through decay, squares and threshold (only
// decay X for non-updates), then commits once the result register is free.
// ----------------------------------------------------------------------------

module otsm_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   det_valid,
	output logic                  det_stall,
	output logic                  res_valid,
	input  wire                   res_stall,
	input  wire otsm_pkg::stat_t  stat,
	output otsm_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECAY_X,
		S_DECAY_Y,
		S_SQUARE_X,
		S_SQUARE_Y,
		S_THRESH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   res_free;

	assign res_free  = !res_valid_q || !res_stall;
	assign det_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = otsm_pkg::MUL_THRESH;
		case (state_q)
			S_IDLE: begin
				cmd.ld_item = det_valid;
			end
			S_DECAY_X: begin
				cmd.mul_sel = otsm_pkg::MUL_DECAY_X;
			end
			S_DECAY_Y: begin
				cmd.mul_sel = otsm_pkg::MUL_DECAY_Y;
				cmd.ld_dx   = 1'b1;
			end
			S_SQUARE_X: begin
				cmd.mul_sel = otsm_pkg::MUL_SQUARE_X;
				cmd.ld_dy   = 1'b1;
			end
			S_SQUARE_Y: begin
				cmd.mul_sel = otsm_pkg::MUL_SQUARE_Y;
				cmd.sum_ld  = 1'b1;
			end
			S_THRESH: begin
				cmd.mul_sel = otsm_pkg::MUL_THRESH;
				cmd.sum_add = 1'b1;
			end
			S_COMMIT: begin
				// hold thr^2 in the product register while waiting
				cmd.mul_sel = otsm_pkg::MUL_THRESH;
				cmd.commit  = res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (det_valid)
						state_q <= S_DECAY_X;
				end
				S_DECAY_X: begin
					state_q <= stat.is_update ? S_DECAY_Y : S_COMMIT;
				end
				S_DECAY_Y:  state_q <= S_SQUARE_X;
				S_SQUARE_X: state_q <= S_SQUARE_Y;
				S_SQUARE_Y: state_q <= S_THRESH;
				S_THRESH:   state_q <= S_COMMIT;
				S_COMMIT: begin
					if (res_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/otsm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otsm_dp - datapath of the object track status machine
// Track state, one shared signed multiplier, decay/saturate and commit logic.
// ----------------------------------------------------------------------------

module otsm_dp #(
	parameter int FRAC_BITS = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire otsm_pkg::det_word_t   det_word,
	input  wire otsm_pkg::cfg_t        cfg,
	input  wire otsm_pkg::obj_load_t   obj_load,
	input  wire otsm_pkg::cmd_t        cmd,
	output otsm_pkg::stat_t            stat,
	output otsm_pkg::res_word_t        res_word
);

	localparam int CB     = otsm_pkg::COORD_BITS;
	localparam int DB     = otsm_pkg::DISP_BITS;
	localparam int MUL_W  = (CB + 1 + FRAC_BITS > DB + 1) ? CB + 1 + FRAC_BITS : DB + 1;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic signed [MUL_W-1:0]  DECAY_OP = MUL_W'(otsm_pkg::DECAY_Q16);
	localparam logic signed [PROD_W-1:0] ROUND_OP = PROD_W'(1 << (otsm_pkg::DECAY_SHIFT - 1));
	localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'((1 << (DB - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO   = -SAT_HI - PROD_W'(1);
	localparam logic [otsm_pkg::TICK_BITS-1:0] TICK_MAX = '1;

	otsm_pkg::det_word_t item_q;

	logic [CB-1:0]             obj_x_q, obj_y_q;
	logic signed [DB-1:0]      accum_dx_q, accum_dy_q;
	logic [otsm_pkg::TICK_BITS-1:0] unseen_q;
	logic seen_q, visible_q, gone_q, moving_q;
	logic rep_vis_q, rep_mov_q, rep_occ_q, rep_gone_q;

	logic signed [DB-1:0]     dx_q, dy_q;
	logic signed [PROD_W-1:0] prod_q, sum_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b, thr_op;
	logic signed [PROD_W-1:0] dec_val, disp_next;
	logic signed [CB:0]       diff;

	logic match, tol_lo_ok, tol_hi_ok;

	// next-state view at commit
	logic [CB-1:0]        obj_x_d, obj_y_d;
	logic signed [DB-1:0] accum_dx_d, accum_dy_d;
	logic [otsm_pkg::TICK_BITS-1:0] unseen_d, cnt_inc;
	logic seen_d, visible_d, gone_d, moving_d;
	logic rep_vis_d, rep_mov_d, rep_occ_d, rep_gone_d;
	logic accepted_d, mv;

	function automatic logic signed [PROD_W-1:0] sat_disp(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI;
		else if (v < SAT_LO)
			r = SAT_LO;
		else
			r = v;
		return r;
	endfunction

	// color - tol < mean < color + tol
	assign tol_lo_ok = ({1'b0, cfg.mean_color} + {1'b0, cfg.color_tolerance})
		> {1'b0, item_q.color};
	assign tol_hi_ok = ({1'b0, item_q.color} + {1'b0, cfg.color_tolerance})
		> {1'b0, cfg.mean_color};
	assign match = tol_lo_ok && tol_hi_ok;

	assign stat.is_update = (item_q.operation == otsm_pkg::OP_DETECT) && item_q.check_color
		&& cfg.tracking_enabled && match;

	assign thr_op = $signed(MUL_W'(cfg.motion_threshold)) <<< FRAC_BITS;

	always_comb begin
		case (cmd.mul_sel)
			otsm_pkg::MUL_DECAY_X: begin
				mul_a = MUL_W'(accum_dx_q);
				mul_b = DECAY_OP;
			end
			otsm_pkg::MUL_DECAY_Y: begin
				mul_a = MUL_W'(accum_dy_q);
				mul_b = DECAY_OP;
			end
			otsm_pkg::MUL_SQUARE_X: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			otsm_pkg::MUL_SQUARE_Y: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			default: begin
				mul_a = thr_op;
				mul_b = thr_op;
			end
		endcase
	end

	// rounded decay plus (old - new) << FRAC, shared by both axes
	always_comb begin
		if (cmd.ld_dy)
			diff = $signed({1'b0, obj_y_q}) - $signed({1'b0, item_q.pos_y});
		else
			diff = $signed({1'b0, obj_x_q}) - $signed({1'b0, item_q.pos_x});
		dec_val   = (prod_q + ROUND_OP) >>> otsm_pkg::DECAY_SHIFT;
		disp_next = sat_disp(dec_val + (PROD_W'(diff) <<< FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.ld_item)
			item_q <= det_word;
		if (cmd.ld_dx)
			dx_q <= DB'(disp_next);
		if (cmd.ld_dy)
			dy_q <= DB'(disp_next);
		if (cmd.sum_ld)
			sum_q <= prod_q;
		else if (cmd.sum_add)
			sum_q <= sum_q + prod_q;
	end

	always_comb begin
		obj_x_d    = obj_x_q;
		obj_y_d    = obj_y_q;
		accum_dx_d = accum_dx_q;
		accum_dy_d = accum_dy_q;
		unseen_d   = unseen_q;
		seen_d     = seen_q;
		visible_d  = visible_q;
		gone_d     = gone_q;
		moving_d   = moving_q;
		rep_vis_d  = rep_vis_q;
		rep_mov_d  = rep_mov_q;
		rep_occ_d  = rep_occ_q;
		rep_gone_d = rep_gone_q;
		accepted_d = 1'b0;
		mv         = sum_q > prod_q;
		cnt_inc    = (unseen_q != TICK_MAX) ? unseen_q + 1'b1 : unseen_q;

		if (item_q.operation == otsm_pkg::OP_DETECT) begin
			if (!item_q.check_color || stat.is_update) begin
				seen_d     = 1'b1;
				visible_d  = 1'b1;
				rep_vis_d  = 1'b1;
				gone_d     = 1'b0;
				rep_occ_d  = 1'b0;
				rep_gone_d = 1'b0;
			end
			if (stat.is_update) begin
				obj_x_d    = item_q.pos_x;
				obj_y_d    = item_q.pos_y;
				unseen_d   = '0;
				moving_d   = mv;
				rep_mov_d  = mv;
				// a moving update restarts the displacement
				accum_dx_d = mv ? '0 : dx_q;
				accum_dy_d = mv ? '0 : dy_q;
				accepted_d = 1'b1;
			end else if (item_q.check_color && cfg.tracking_enabled) begin
				seen_d    = 1'b0;
				moving_d  = 1'b0;
				rep_mov_d = 1'b0;
				rep_vis_d = visible_q;
			end
		end else begin
			if (!seen_q) begin
				unseen_d  = cnt_inc;
				rep_vis_d = 1'b0;
				if (cnt_inc > cfg.occlude_ticks && cnt_inc < cfg.gone_ticks) begin
					if (visible_q)
						rep_occ_d = 1'b1;
					visible_d = 1'b0;
				end else if (cnt_inc >= cfg.gone_ticks) begin
					if (!gone_q) begin
						rep_gone_d = 1'b1;
						rep_occ_d  = 1'b0;
					end else begin
						rep_gone_d = 1'b0;
					end
					gone_d = 1'b1;
				end
			end
			seen_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_x_q    <= '0;
			obj_y_q    <= '0;
			accum_dx_q <= '0;
			accum_dy_q <= '0;
			unseen_q   <= '0;
			seen_q     <= 1'b0;
			visible_q  <= 1'b0;
			gone_q     <= 1'b0;
			moving_q   <= 1'b0;
			rep_vis_q  <= 1'b0;
			rep_mov_q  <= 1'b0;
			rep_occ_q  <= 1'b0;
			rep_gone_q <= 1'b0;
		end else if (cmd.commit) begin
			obj_x_q    <= obj_x_d;
			obj_y_q    <= obj_y_d;
			accum_dx_q <= accum_dx_d;
			accum_dy_q <= accum_dy_d;
			unseen_q   <= unseen_d;
			seen_q     <= seen_d;
			visible_q  <= visible_d;
			gone_q     <= gone_d;
			moving_q   <= moving_d;
			rep_vis_q  <= rep_vis_d;
			rep_mov_q  <= rep_mov_d;
			rep_occ_q  <= rep_occ_d;
			rep_gone_q <= rep_gone_d;
		end else begin
			if (obj_load.ld_x)
				obj_x_q <= obj_load.value;
			if (obj_load.ld_y)
				obj_y_q <= obj_load.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_word.accepted  <= accepted_d;
			res_word.status    <= otsm_pkg::status_code(rep_vis_d, rep_mov_d,
				rep_occ_d, rep_gone_d);
			res_word.in_motion <= moving_d;
			res_word.disp_x    <= accum_dx_d;
			res_word.disp_y    <= accum_dy_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/object_track_status_machine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// object_track_status_machine - status keeper for one tracked object
// Detection words update position, decayed displacement and motion flags;
// tick words age an unseen object to occluded and then gone.
// ----------------------------------------------------------------------------
// Sequence: a colour-checked detection that matches, with tracking on, steps
//   through decay X, decay Y, square X, square Y, threshold and commit; every
//   other word goes from decay X straight to commit, which waits for a free
//   result register. Throughput: one word in flight; the one shared multiplier
//   forms the two decay products, the two squares and the squared threshold.
// Reset: arst_n clears all track state and loads register defaults
//   (tolerance 5, threshold 30, occlude 10, gone 60, tracking on).

module object_track_status_machine #(
	parameter int FRAC_BITS = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// detection / tick words
	input  wire                       det_valid,
	output logic                      det_stall,
	input  wire otsm_pkg::det_word_t  det_word,
	// result words
	output logic                      res_valid,
	input  wire                       res_stall,
	output otsm_pkg::res_word_t       res_word,
	// register port
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire  [4:0]                paddr,
	input  wire  [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	// register index = paddr[4:2]
	localparam logic [2:0] REG_MEAN_COLOR  = 3'd0;
	localparam logic [2:0] REG_START_X     = 3'd1;
	localparam logic [2:0] REG_START_Y     = 3'd2;
	localparam logic [2:0] REG_COLOR_TOL   = 3'd3;
	localparam logic [2:0] REG_MOTION_THR  = 3'd4;
	localparam logic [2:0] REG_OCCLUDE     = 3'd5;
	localparam logic [2:0] REG_GONE        = 3'd6;
	localparam logic [2:0] REG_TRACK_EN    = 3'd7;

	localparam int CB = otsm_pkg::COORD_BITS;
	localparam int KB = otsm_pkg::COLOR_BITS;
	localparam int TB = otsm_pkg::TICK_BITS;

	otsm_pkg::cfg_t      cfg_q;
	otsm_pkg::obj_load_t obj_load;
	otsm_pkg::cmd_t      cmd;
	otsm_pkg::stat_t     stat;

	logic       reg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// a start position write also moves the stored position, unless a commit lands in the same cycle
	assign obj_load.ld_x  = reg_wr && (reg_idx == REG_START_X);
	assign obj_load.ld_y  = reg_wr && (reg_idx == REG_START_Y);
	assign obj_load.value = pwdata[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_color       <= '0;
			cfg_q.start_x          <= '0;
			cfg_q.start_y          <= '0;
			cfg_q.color_tolerance  <= KB'(5);
			cfg_q.motion_threshold <= CB'(30);
			cfg_q.occlude_ticks    <= TB'(10);
			cfg_q.gone_ticks       <= TB'(60);
			cfg_q.tracking_enabled <= 1'b1;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_MEAN_COLOR: cfg_q.mean_color       <= pwdata[KB-1:0];
				REG_START_X:    cfg_q.start_x          <= pwdata[CB-1:0];
				REG_START_Y:    cfg_q.start_y          <= pwdata[CB-1:0];
				REG_COLOR_TOL:  cfg_q.color_tolerance  <= pwdata[KB-1:0];
				REG_MOTION_THR: cfg_q.motion_threshold <= pwdata[CB-1:0];
				REG_OCCLUDE:    cfg_q.occlude_ticks    <= pwdata[TB-1:0];
				REG_GONE:       cfg_q.gone_ticks       <= pwdata[TB-1:0];
				REG_TRACK_EN:   cfg_q.tracking_enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MEAN_COLOR: prdata = 32'(cfg_q.mean_color);
			REG_START_X:    prdata = 32'(cfg_q.start_x);
			REG_START_Y:    prdata = 32'(cfg_q.start_y);
			REG_COLOR_TOL:  prdata = 32'(cfg_q.color_tolerance);
			REG_MOTION_THR: prdata = 32'(cfg_q.motion_threshold);
			REG_OCCLUDE:    prdata = 32'(cfg_q.occlude_ticks);
			REG_GONE:       prdata = 32'(cfg_q.gone_ticks);
			REG_TRACK_EN:   prdata = 32'(cfg_q.tracking_enabled);
			default:        prdata = '0;
		endcase
	end

	otsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_stall (det_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	otsm_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.det_word (det_word),
		.cfg      (cfg_q),
		.obj_load (obj_load),
		.cmd      (cmd),
		.stat     (stat),
		.res_word (res_word)
	);

	// ---- checks ----

	// a new result only appears after a commit
	a_res_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.commit))
		else $error("result valid without commit");

	// commit never overwrites a stalled result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(res_valid && res_stall))
		else $error("commit over stalled result");

	// an accepted update always reports stationary or moving
	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.accepted) |->
		(res_word.status == otsm_pkg::STATUS_STATIONARY ||
		 res_word.status == otsm_pkg::STATUS_MOVING))
		else $error("accepted update with odd status");

	// a moving update restarts the displacement
	a_moving_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.accepted && res_word.in_motion) |->
		(res_word.disp_x == '0 && res_word.disp_y == '0))
		else $error("moving update kept displacement");

endmodule

`default_nettype wire
